@@ rtl/core/i2cee_pkg.sv @@
// shared types and constants for the i2c eeprom byte master
// no dependencies; used by every module of the block
package i2cee_pkg;

    localparam int CFG_IDX_W = 1;
    localparam int BYTE_W    = 8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEV_ADDR    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACK_TIMEOUT = 1'd1;

    localparam logic [BYTE_W-1:0] RST_DEV_ADDR    = 8'ha0;
    localparam logic [BYTE_W-1:0] RST_ACK_TIMEOUT = 8'd200;

    // request kinds
    localparam logic [1:0] KIND_PLAIN = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    typedef struct packed {
        logic [BYTE_W-1:0] dev_addr;
        logic [BYTE_W-1:0] ack_timeout;
    } t_cfg;

    typedef struct packed {
        logic              scl_out;
        logic              sda_out;
        logic              busy_res;
        logic              done_res;
        logic [BYTE_W-1:0] read_data;
        logic              ack_missing;
    } t_result;

endpackage

@@ rtl/core/i2cee_cfg.sv @@
// configuration registers: device write address and ack timeout
// depends on i2cee_pkg
module i2cee_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [i2cee_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [i2cee_pkg::BYTE_W-1:0]   i_cfg_data,
    output i2cee_pkg::t_cfg                o_cfg
);

    i2cee_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dev_addr    <= i2cee_pkg::RST_DEV_ADDR;
            r_cfg.ack_timeout <= i2cee_pkg::RST_ACK_TIMEOUT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                i2cee_pkg::REG_DEV_ADDR:    r_cfg.dev_addr    <= i_cfg_data;
                i2cee_pkg::REG_ACK_TIMEOUT: r_cfg.ack_timeout <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ rtl/core/i2cee_seq.sv @@
// slot sequencer: bus state machine, shift registers and ack poll counter
// depends on i2cee_pkg; advances one bus slot per accepted item
module i2cee_seq (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_step,
    input  i2cee_pkg::t_cfg              i_cfg,
    input  logic [1:0]                   i_kind,
    input  logic [i2cee_pkg::BYTE_W-1:0] i_mem_address,
    input  logic [i2cee_pkg::BYTE_W-1:0] i_write_data,
    input  logic                         i_sda_in,
    output i2cee_pkg::t_result           o_result
);

    localparam logic [4:0] PH_IDLE     = 5'd0;
    localparam logic [4:0] PH_ST_A     = 5'd1;
    localparam logic [4:0] PH_ST_B     = 5'd2;
    localparam logic [4:0] PH_ST_C     = 5'd3;
    localparam logic [4:0] PH_TX_SET   = 5'd4;
    localparam logic [4:0] PH_TX_HIGH  = 5'd5;
    localparam logic [4:0] PH_TX_LOW   = 5'd6;
    localparam logic [4:0] PH_ACK_REL  = 5'd7;
    localparam logic [4:0] PH_ACK_POLL = 5'd8;
    localparam logic [4:0] PH_ACK_END  = 5'd9;
    localparam logic [4:0] PH_RX_REL   = 5'd10;
    localparam logic [4:0] PH_RX_HIGH  = 5'd11;
    localparam logic [4:0] PH_RX_LOW   = 5'd12;
    localparam logic [4:0] PH_NK_HIGH  = 5'd13;
    localparam logic [4:0] PH_NK_LOW   = 5'd14;
    localparam logic [4:0] PH_SP_A     = 5'd15;
    localparam logic [4:0] PH_SP_B     = 5'd16;
    localparam logic [4:0] PH_SP_C     = 5'd17;

    localparam logic [2:0] IDX_DEV  = 3'd0;
    localparam logic [2:0] IDX_MEM  = 3'd1;
    localparam logic [2:0] IDX_LAST = 3'd2;

    logic [4:0] r_phase,       n_phase;
    logic [3:0] r_bit_count,   n_bit_count;
    logic [2:0] r_byte_index,  n_byte_index;
    logic [7:0] r_send_shift,  n_send_shift;
    logic [7:0] r_recv_shift,  n_recv_shift;
    logic [7:0] r_wait_count,  n_wait_count;
    logic [7:0] r_lat_addr,    n_lat_addr;
    logic [7:0] r_lat_data,    n_lat_data;
    logic       r_is_read,     n_is_read;
    logic       r_ack_fail,    n_ack_fail;
    logic [1:0] r_line,        n_line;
    logic [7:0] r_read_result, n_read_result;
    logic       busy;
    logic       done;
    logic [7:0] wait_inc;

    // byte that goes out for a given position in the transaction
    function automatic logic [7:0] pick_byte(
        input logic [2:0] idx,
        input logic       is_read,
        input logic [7:0] dev_addr,
        input logic [7:0] lat_addr,
        input logic [7:0] lat_data
    );
        logic [7:0] b;
        unique case (idx)
            IDX_DEV:  b = dev_addr;
            IDX_MEM:  b = lat_addr;
            IDX_LAST: b = is_read ? dev_addr + 8'd1 : lat_data;
            default:  b = 8'd0;
        endcase
        return b;
    endfunction

    always_comb begin
        n_phase       = r_phase;
        n_bit_count   = r_bit_count;
        n_byte_index  = r_byte_index;
        n_send_shift  = r_send_shift;
        n_recv_shift  = r_recv_shift;
        n_wait_count  = r_wait_count;
        n_lat_addr    = r_lat_addr;
        n_lat_data    = r_lat_data;
        n_is_read     = r_is_read;
        n_ack_fail    = r_ack_fail;
        n_line        = r_line;
        n_read_result = r_read_result;
        busy          = 1'b1;
        done          = 1'b0;
        wait_inc      = (r_wait_count != 8'hff) ? r_wait_count + 8'd1 : r_wait_count;

        if (r_phase == PH_IDLE &&
            (i_kind == i2cee_pkg::KIND_WRITE || i_kind == i2cee_pkg::KIND_READ)) begin
            n_lat_addr   = i_mem_address;
            n_lat_data   = i_write_data;
            n_is_read    = (i_kind == i2cee_pkg::KIND_READ);
            n_ack_fail   = 1'b0;
            n_byte_index = 3'd0;
            n_phase      = PH_ST_A;
        end

        unique case (n_phase)
            PH_IDLE: begin
                busy   = 1'b0;
                n_line = 2'b11;
            end
            PH_ST_A: begin
                n_line  = 2'b11;
                n_phase = PH_ST_B;
            end
            PH_ST_B: begin
                n_line  = 2'b10;
                n_phase = PH_ST_C;
            end
            PH_ST_C: begin
                n_line       = 2'b00;
                n_send_shift = pick_byte(n_byte_index, n_is_read, i_cfg.dev_addr,
                                         n_lat_addr, n_lat_data);
                n_bit_count  = 4'd0;
                n_phase      = PH_TX_SET;
            end
            PH_TX_SET: begin
                n_line  = {1'b0, r_send_shift[7]};
                n_phase = PH_TX_HIGH;
            end
            PH_TX_HIGH: begin
                n_line  = {1'b1, r_line[0]};
                n_phase = PH_TX_LOW;
            end
            PH_TX_LOW: begin
                n_line       = {1'b0, r_line[0]};
                n_send_shift = {r_send_shift[6:0], 1'b0};
                n_bit_count  = r_bit_count + 4'd1;
                n_phase      = n_bit_count[3] ? PH_ACK_REL : PH_TX_SET;
            end
            PH_ACK_REL: begin
                n_line       = 2'b01;
                n_wait_count = 8'd0;
                n_phase      = PH_ACK_POLL;
            end
            PH_ACK_POLL: begin
                n_line = 2'b11;
                if (!i_sda_in) begin
                    n_phase = PH_ACK_END;
                end else begin
                    n_wait_count = wait_inc;
                    if (wait_inc >= i_cfg.ack_timeout) begin
                        n_ack_fail = 1'b1;
                        n_phase    = PH_ACK_END;
                    end
                end
            end
            PH_ACK_END: begin
                n_line       = 2'b01;
                n_byte_index = r_byte_index + 3'd1;
                // reads turn around with a repeated start after the memory address
                if (r_is_read && n_byte_index == IDX_LAST) begin
                    n_phase = PH_ST_A;
                end else if (n_byte_index >= 3'd3) begin
                    n_phase = r_is_read ? PH_RX_REL : PH_SP_A;
                end else begin
                    n_send_shift = pick_byte(n_byte_index, r_is_read, i_cfg.dev_addr,
                                             r_lat_addr, r_lat_data);
                    n_bit_count  = 4'd0;
                    n_phase      = PH_TX_SET;
                end
            end
            PH_RX_REL: begin
                n_line       = 2'b01;
                n_bit_count  = 4'd0;
                n_recv_shift = 8'd0;
                n_phase      = PH_RX_HIGH;
            end
            PH_RX_HIGH: begin
                n_line       = 2'b11;
                n_recv_shift = {r_recv_shift[6:0], i_sda_in};
                n_phase      = PH_RX_LOW;
            end
            PH_RX_LOW: begin
                n_line      = 2'b01;
                n_bit_count = r_bit_count + 4'd1;
                n_phase     = n_bit_count[3] ? PH_NK_HIGH : PH_RX_HIGH;
            end
            PH_NK_HIGH: begin
                n_line  = 2'b11;
                n_phase = PH_NK_LOW;
            end
            PH_NK_LOW: begin
                n_line  = 2'b01;
                n_phase = PH_SP_A;
            end
            PH_SP_A: begin
                n_line  = 2'b00;
                n_phase = PH_SP_B;
            end
            PH_SP_B: begin
                n_line  = 2'b10;
                n_phase = PH_SP_C;
            end
            PH_SP_C: begin
                n_line = 2'b11;
                done   = 1'b1;
                if (r_is_read) begin
                    n_read_result = r_recv_shift;
                end
                n_phase = PH_IDLE;
            end
            default: begin
                busy    = 1'b0;
                n_line  = 2'b11;
                n_phase = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_bit_count   <= 4'd0;
            r_byte_index  <= 3'd0;
            r_send_shift  <= 8'd0;
            r_recv_shift  <= 8'd0;
            r_wait_count  <= 8'd0;
            r_lat_addr    <= 8'd0;
            r_lat_data    <= 8'd0;
            r_is_read     <= 1'b0;
            r_ack_fail    <= 1'b0;
            r_line        <= 2'b11;
            r_read_result <= 8'd0;
        end else if (i_step) begin
            r_phase       <= n_phase;
            r_bit_count   <= n_bit_count;
            r_byte_index  <= n_byte_index;
            r_send_shift  <= n_send_shift;
            r_recv_shift  <= n_recv_shift;
            r_wait_count  <= n_wait_count;
            r_lat_addr    <= n_lat_addr;
            r_lat_data    <= n_lat_data;
            r_is_read     <= n_is_read;
            r_ack_fail    <= n_ack_fail;
            r_line        <= n_line;
            r_read_result <= n_read_result;
        end
    end

    assign o_result.scl_out     = n_line[1];
    assign o_result.sda_out     = n_line[0];
    assign o_result.busy_res    = busy;
    assign o_result.done_res    = done;
    assign o_result.read_data   = n_read_result;
    assign o_result.ack_missing = n_ack_fail;

endmodule

@@ rtl/core/i2c_eeprom_byte_master.sv @@
// i2c eeprom byte master top level: handshake, result register, submodules
// depends on i2cee_pkg, i2cee_cfg, i2cee_seq
// the result item of a slot is registered, valid in the cycle after its slot item is accepted
// one slot item per cycle unless stalled; sequencer state and result register update together
// the result register frees up in the same cycle its item is taken, so no bubble on stall release
// reset is synchronous, active low: sequencer idle with both lines high, config back to defaults
module i2c_eeprom_byte_master (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [i2cee_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [i2cee_pkg::BYTE_W-1:0]     i_cfg_data,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [1:0]                       i_kind,
    input  logic [i2cee_pkg::BYTE_W-1:0]     i_mem_address,
    input  logic [i2cee_pkg::BYTE_W-1:0]     i_write_data,
    input  logic                             i_sda_in,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic                             o_scl_out,
    output logic                             o_sda_out,
    output logic                             o_busy_res,
    output logic                             o_done_res,
    output logic [i2cee_pkg::BYTE_W-1:0]     o_read_data,
    output logic                             o_ack_missing
);

    i2cee_pkg::t_cfg    cfg;
    i2cee_pkg::t_result result;
    i2cee_pkg::t_result r_out;
    logic               r_out_valid;
    logic               accept;

    assign o_stall = r_out_valid & i_stall;
    assign accept  = i_valid & ~o_stall;

    i2cee_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    i2cee_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (accept),
        .i_cfg         (cfg),
        .i_kind        (i_kind),
        .i_mem_address (i_mem_address),
        .i_write_data  (i_write_data),
        .i_sda_in      (i_sda_in),
        .o_result      (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= result;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_scl_out     = r_out.scl_out;
    assign o_sda_out     = r_out.sda_out;
    assign o_busy_res    = r_out.busy_res;
    assign o_done_res    = r_out.done_res;
    assign o_read_data   = r_out.read_data;
    assign o_ack_missing = r_out.ack_missing;

endmodule

@@ bench/tb_top.sv @@
// self-checking bench for the i2c eeprom byte master: one slot item in, one result item out
// a scoreboard class predicts every slot; depends on i2cee_pkg and the i2c_eeprom_byte_master rtl
module tb_top;

    localparam int ITEM_TARGET  = 1950;
    localparam int PHASE_ITEMS  = 650;
    localparam int STALL_LIMIT  = 5000;

    // unused kind code, must act as a plain slot
    localparam logic [1:0] KIND_SPARE = 2'd3;

    typedef enum logic [4:0] {
        B_IDLE, B_START1, B_START2, B_START3, B_TX_SETUP, B_TX_HIGH, B_TX_LOW,
        B_ACK_REL, B_ACK_POLL, B_ACK_END, B_RX_REL, B_RX_HIGH, B_RX_LOW,
        B_NACK_HIGH, B_NACK_LOW, B_STOP1, B_STOP2, B_STOP3
    } t_bus_step;

    typedef enum {ACK_GIVEN, ACK_WITHHELD, ACK_RANDOM} t_ack_style;

    class i2c_slot_board;
        logic [7:0] dev_addr  = i2cee_pkg::RST_DEV_ADDR;
        logic [7:0] ack_limit = i2cee_pkg::RST_ACK_TIMEOUT;
        t_bus_step  st        = B_IDLE;
        logic [3:0] bit_cnt   = '0;
        logic [2:0] byte_idx  = '0;
        logic [7:0] tx_byte   = '0;
        logic [7:0] rx_byte   = '0;
        logic [7:0] poll_cnt  = '0;
        logic [7:0] req_addr  = '0;
        logic [7:0] req_data  = '0;
        logic       rd_req    = 1'b0;
        logic       nack_seen = 1'b0;
        logic       scl       = 1'b1;
        logic       sda       = 1'b1;
        logic [7:0] last_read = '0;
        i2cee_pkg::t_result pending_slots[$];
        int         error_count = 0;

        function void set_regs(logic [7:0] dev, logic [7:0] lim);
            dev_addr  = dev;
            ack_limit = lim;
        endfunction

        function bit bus_idle();
            return st == B_IDLE;
        endfunction

        function bit in_ack_poll();
            return st == B_ACK_POLL;
        endfunction

        function int pending();
            return pending_slots.size();
        endfunction

        function void load_byte();
            case (byte_idx)
                3'd0: tx_byte = dev_addr;
                3'd1: tx_byte = req_addr;
                3'd2: tx_byte = rd_req ? dev_addr + 8'd1 : req_data;
                default: tx_byte = '0;
            endcase
            bit_cnt = '0;
            st = B_TX_SETUP;
        endfunction

        // advance the bus sequencer by one slot and queue the result item it predicts
        function void note_slot(logic [1:0] kind, logic [7:0] addr, logic [7:0] data,
                                logic sda_in);
            i2cee_pkg::t_result want;
            logic    busy;
            logic    done;
            busy = 1'b1;
            done = 1'b0;
            if (st == B_IDLE &&
                (kind == i2cee_pkg::KIND_WRITE || kind == i2cee_pkg::KIND_READ)) begin
                req_addr  = addr;
                req_data  = data;
                rd_req    = (kind == i2cee_pkg::KIND_READ);
                nack_seen = 1'b0;
                byte_idx  = '0;
                st        = B_START1;
            end
            case (st)
                B_IDLE: begin
                    busy = 1'b0;
                    scl = 1'b1; sda = 1'b1;
                end
                B_START1: begin
                    scl = 1'b1; sda = 1'b1; st = B_START2;
                end
                B_START2: begin
                    scl = 1'b1; sda = 1'b0; st = B_START3;
                end
                B_START3: begin
                    scl = 1'b0; sda = 1'b0;
                    load_byte();
                end
                B_TX_SETUP: begin
                    scl = 1'b0; sda = tx_byte[7]; st = B_TX_HIGH;
                end
                B_TX_HIGH: begin
                    scl = 1'b1; st = B_TX_LOW;
                end
                B_TX_LOW: begin
                    scl = 1'b0;
                    tx_byte = tx_byte << 1;
                    bit_cnt = bit_cnt + 4'd1;
                    st = (bit_cnt >= 4'd8) ? B_ACK_REL : B_TX_SETUP;
                end
                B_ACK_REL: begin
                    scl = 1'b0; sda = 1'b1;
                    poll_cnt = '0;
                    st = B_ACK_POLL;
                end
                B_ACK_POLL: begin
                    scl = 1'b1; sda = 1'b1;
                    if (!sda_in) begin
                        st = B_ACK_END;
                    end else begin
                        if (poll_cnt != 8'hff) poll_cnt = poll_cnt + 8'd1;
                        // a limit of zero gives up after one poll, same as one
                        if (poll_cnt >= ack_limit) begin
                            nack_seen = 1'b1;
                            st = B_ACK_END;
                        end
                    end
                end
                B_ACK_END: begin
                    scl = 1'b0; sda = 1'b1;
                    byte_idx = byte_idx + 3'd1;
                    if (rd_req) begin
                        // repeated start before the read address
                        if (byte_idx == 3'd2) st = B_START1;
                        else if (byte_idx >= 3'd3) st = B_RX_REL;
                        else load_byte();
                    end else begin
                        if (byte_idx >= 3'd3) st = B_STOP1;
                        else load_byte();
                    end
                end
                B_RX_REL: begin
                    scl = 1'b0; sda = 1'b1;
                    bit_cnt = '0;
                    rx_byte = '0;
                    st = B_RX_HIGH;
                end
                B_RX_HIGH: begin
                    scl = 1'b1; sda = 1'b1;
                    rx_byte = {rx_byte[6:0], sda_in};
                    st = B_RX_LOW;
                end
                B_RX_LOW: begin
                    scl = 1'b0; sda = 1'b1;
                    bit_cnt = bit_cnt + 4'd1;
                    st = (bit_cnt >= 4'd8) ? B_NACK_HIGH : B_RX_HIGH;
                end
                B_NACK_HIGH: begin
                    scl = 1'b1; sda = 1'b1; st = B_NACK_LOW;
                end
                B_NACK_LOW: begin
                    scl = 1'b0; sda = 1'b1; st = B_STOP1;
                end
                B_STOP1: begin
                    scl = 1'b0; sda = 1'b0; st = B_STOP2;
                end
                B_STOP2: begin
                    scl = 1'b1; sda = 1'b0; st = B_STOP3;
                end
                B_STOP3: begin
                    scl = 1'b1; sda = 1'b1;
                    done = 1'b1;
                    if (rd_req) last_read = rx_byte;
                    st = B_IDLE;
                end
                default: begin
                    busy = 1'b0;
                    scl = 1'b1; sda = 1'b1;
                    st = B_IDLE;
                end
            endcase
            want.scl_out     = scl;
            want.sda_out     = sda;
            want.busy_res    = busy;
            want.done_res    = done;
            want.read_data   = last_read;
            want.ack_missing = nack_seen;
            pending_slots.push_back(want);
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $error("%s: expected %0h, got %0h", name, want, got);
                error_count++;
            end
        endfunction

        function void check_slot(i2cee_pkg::t_result got);
            i2cee_pkg::t_result want;
            if (pending_slots.size() == 0) begin
                $error("result item with nothing expected");
                error_count++;
                return;
            end
            want = pending_slots.pop_front();
            compare_field("scl_out", 8'(want.scl_out), 8'(got.scl_out));
            compare_field("sda_out", 8'(want.sda_out), 8'(got.sda_out));
            compare_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
            compare_field("done_res", 8'(want.done_res), 8'(got.done_res));
            compare_field("read_data", want.read_data, got.read_data);
            compare_field("ack_missing", 8'(want.ack_missing), 8'(got.ack_missing));
        endfunction
    endclass

    logic                              i_clk         = 1'b0;
    logic                              i_rst_n       = 1'b0;
    logic                              i_cfg_we      = 1'b0;
    logic [i2cee_pkg::CFG_IDX_W-1:0]   i_cfg_index   = '0;
    logic [i2cee_pkg::BYTE_W-1:0]      i_cfg_data    = '0;
    logic                              i_valid       = 1'b0;
    logic                              o_stall;
    logic [1:0]                        i_kind        = i2cee_pkg::KIND_PLAIN;
    logic [i2cee_pkg::BYTE_W-1:0]      i_mem_address = '0;
    logic [i2cee_pkg::BYTE_W-1:0]      i_write_data  = '0;
    logic                              i_sda_in      = 1'b1;
    logic                              o_valid;
    logic                              i_stall       = 1'b0;
    logic                              o_scl_out;
    logic                              o_sda_out;
    logic                              o_busy_res;
    logic                              o_done_res;
    logic [i2cee_pkg::BYTE_W-1:0]      o_read_data;
    logic                              o_ack_missing;

    i2c_slot_board sb = new;
    int            sent_count = 0;
    int            send_idle_pct = 7;
    int            recv_idle_pct = 87;
    int            quiet_cycles = 0;

    i2c_eeprom_byte_master dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_kind        (i_kind),
        .i_mem_address (i_mem_address),
        .i_write_data  (i_write_data),
        .i_sda_in      (i_sda_in),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_scl_out     (o_scl_out),
        .o_sda_out     (o_sda_out),
        .o_busy_res    (o_busy_res),
        .o_done_res    (o_done_res),
        .o_read_data   (o_read_data),
        .o_ack_missing (o_ack_missing)
    );

    always begin
        #4;
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && i_stall === 1'b0) begin
            sb.check_slot('{o_scl_out, o_sda_out, o_busy_res, o_done_res,
                            o_read_data, o_ack_missing});
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_stall === 1'b0) || (o_valid === 1'b1 && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // slave side of the bus: ack level in poll slots, random data elsewhere
    function automatic logic pick_sda(t_ack_style style);
        if (!sb.in_ack_poll()) return 1'($urandom_range(1));
        case (style)
            ACK_GIVEN:    return ($urandom_range(7) == 0);
            ACK_WITHHELD: return 1'b1;
            default:      return 1'($urandom_range(1));
        endcase
    endfunction

    task automatic send_slot(input logic [1:0] kind, input logic [7:0] addr,
                             input logic [7:0] data, input logic sda);
        if (sent_count < PHASE_ITEMS) begin
            send_idle_pct = 7;
            recv_idle_pct = 87;
        end else if (sent_count < 2 * PHASE_ITEMS) begin
            send_idle_pct = 87;
            recv_idle_pct = 7;
        end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_kind        <= kind;
        i_mem_address <= addr;
        i_write_data  <= data;
        i_sda_in      <= sda;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        sb.note_slot(kind, addr, data, sda);
        sent_count++;
    endtask

    // one request item, then slots until the bus is idle again
    task automatic run_transfer(input logic [1:0] kind, input logic [7:0] addr,
                                input logic [7:0] data, input t_ack_style style);
        logic [1:0] filler;
        send_slot(kind, addr, data, pick_sda(style));
        while (!sb.bus_idle()) begin
            // occasional requests while busy must be ignored
            filler = ($urandom_range(9) == 0) ? 2'($urandom_range(3))
                                                : i2cee_pkg::KIND_PLAIN;
            send_slot(filler, 8'($urandom), 8'($urandom), pick_sda(style));
        end
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_config(input logic [7:0] dev, input logic [7:0] lim);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= i2cee_pkg::REG_DEV_ADDR;
        i_cfg_data  <= dev;
        @(posedge i_clk);
        i_cfg_index <= i2cee_pkg::REG_ACK_TIMEOUT;
        i_cfg_data  <= lim;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.set_regs(dev, lim);
    endtask

    initial begin
        int         pick;
        logic [7:0] lim;
        logic [1:0] kind;
        t_ack_style style;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: field extremes, both requests, ignored kinds, timeouts, address wrap
        run_transfer(i2cee_pkg::KIND_WRITE, 8'h00, 8'h00, ACK_GIVEN);
        run_transfer(i2cee_pkg::KIND_WRITE, 8'hff, 8'hff, ACK_GIVEN);
        run_transfer(i2cee_pkg::KIND_READ, 8'h5a, 8'h00, ACK_GIVEN);
        send_slot(KIND_SPARE, 8'hff, 8'hff, 1'b0);
        send_slot(i2cee_pkg::KIND_PLAIN, 8'h00, 8'h00, 1'b1);
        write_config(8'hff, 8'd1);
        run_transfer(i2cee_pkg::KIND_READ, 8'h00, 8'hff, ACK_WITHHELD);
        write_config(8'h00, 8'd0);
        run_transfer(i2cee_pkg::KIND_WRITE, 8'h81, 8'h7e, ACK_WITHHELD);
        write_config(8'ha0, 8'd255);
        run_transfer(i2cee_pkg::KIND_READ, 8'hff, 8'h00, ACK_GIVEN);

        while (sent_count < ITEM_TARGET) begin
            if ($urandom_range(5) == 0) begin
                pick = $urandom_range(9);
                if (pick < 6) lim = 8'($urandom_range(6, 1));
                else if (pick == 6) lim = i2cee_pkg::RST_ACK_TIMEOUT;
                else if (pick == 7) lim = 8'd255;
                else lim = 8'($urandom_range(255, 1));
                write_config(8'($urandom), lim);
            end
            pick = $urandom_range(9);
            if (pick == 0) begin
                kind = ($urandom_range(1) == 0) ? i2cee_pkg::KIND_PLAIN : KIND_SPARE;
            end else begin
                kind = (pick < 5) ? i2cee_pkg::KIND_WRITE : i2cee_pkg::KIND_READ;
            end
            pick = $urandom_range(3);
            if (sb.ack_limit <= 8'd8 && pick == 0) style = ACK_WITHHELD;
            else if (pick == 1) style = ACK_RANDOM;
            else style = ACK_GIVEN;
            run_transfer(kind, 8'($urandom), 8'($urandom), style);
        end

        drain_results();
        repeat (4) @(posedge i_clk);
        if (sb.error_count == 0 && sb.pending() == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end
endmodule
